// ===== src/lsia_pkg.sv =====
// Shared constants for the LIFO stack with indexed access: field widths,
// stream bit positions, opcodes and status codes. No dependencies.
package lsia_pkg;

   localparam int OPCODE_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 4;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam int REQ_OPCODE_LSB   = 0;
   localparam int REQ_VALUE_LSB    = REQ_OPCODE_LSB + OPCODE_W;
   localparam int REQ_POSITION_LSB = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_USED_W       = REQ_POSITION_LSB + POSITION_W;

   localparam int RSP_USED_W = VALUE_W + STATUS_W + COUNT_W;

   localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_PEEK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

// ===== src/lifo_stack_with_indexed_access_core.sv =====
// LIFO stack with indexed access: sequencer, entry count and result register.
// Push, and any request that finds no entry, passes through S_FINISH to its result;
// pop, peek and read pass S_FETCH first; remove also moves any entries above it down
// in S_SHIFT, one entry per cycle, through the RAM write port. One request is worked at a
// time, the next transfer is taken once the result is posted, and a stalled result holds it.
// Synchronous active-high reset empties the stack and drops any pending result.
module lifo_stack_with_indexed_access_core import lsia_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode[2:0], push_value[34:3], position[38:35], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // value[31:0], status[33:32], count[38:34], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > POSITION_W) ? CW : POSITION_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [AW-1:0]           k_ff, k_in;
   logic                    remove_ff, remove_in;
   logic [DATA_WIDTH-1:0]   res_value_ff, res_value_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                    req_accept;
   logic [OPCODE_W-1:0]     req_opcode;
   logic [VALUE_W-1:0]      req_push_value;
   logic [POSITION_W-1:0]   req_position;
   logic                    pos_missing;

   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   logic [DATA_WIDTH-1:0]   mem_wr_data;
   logic [AW-1:0]           mem_rd_addr;
   logic [DATA_WIDTH-1:0]   mem_rd_data;

   assign req_opcode     = req_tdata[REQ_OPCODE_LSB +: OPCODE_W];
   assign req_push_value = req_tdata[REQ_VALUE_LSB +: VALUE_W];
   assign req_position   = req_tdata[REQ_POSITION_LSB +: POSITION_W];
   assign req_tready     = (state_ff == S_IDLE);
   assign req_accept     = req_tvalid && req_tready;
   assign pos_missing    = CMP_W'(req_position) >= CMP_W'(count_ff);

   lsia_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      remove_in     = remove_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = AW'(count_ff);
      mem_wr_data   = DATA_WIDTH'(req_push_value);
      mem_rd_addr   = AW'(count_ff - CW'(1));

      case (state_ff)
         S_IDLE: begin
            if ((req_opcode == OP_READ) || (req_opcode == OP_REMOVE)) begin
               mem_rd_addr = AW'(req_position);
            end
            if (req_accept) begin
               pos_in        = AW'(req_position);
               remove_in     = (req_opcode == OP_REMOVE);
               res_value_in  = '0;
               res_status_in = ST_NOT_FOUND;
               state_in      = S_FINISH;
               case (req_opcode)
                  OP_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_wr_en     = 1'b1;
                        count_in      = count_ff + CW'(1);
                        res_status_in = ST_OK;
                     end
                  end
                  OP_POP: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                        state_in = S_FETCH;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff != '0) begin
                        state_in = S_FETCH;
                     end
                  end
                  OP_REMOVE: begin
                     if (!pos_missing) begin
                        count_in = count_ff - CW'(1);
                        state_in = S_FETCH;
                     end
                  end
                  OP_READ: begin
                     if (!pos_missing) begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_FETCH: begin
            res_value_in  = mem_rd_data;
            res_status_in = ST_OK;
            mem_rd_addr   = AW'(pos_ff + AW'(1));
            k_in          = pos_ff;
            if (remove_ff && (CW'(pos_ff) < count_ff)) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = k_ff;
            mem_wr_data = mem_rd_data;
            mem_rd_addr = AW'({1'b0, k_ff} + (AW + 1)'(2));
            if ((CW'(k_ff) + CW'(1)) < count_ff) begin
               k_in = k_ff + AW'(1);
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_value_in  = VALUE_W'(res_value_ff);
               rsp_status_in = res_status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      pos_ff        <= pos_in;
      k_ff          <= k_in;
      remove_ff     <= remove_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), rsp_count_ff, rsp_status_ff,
                        rsp_value_ff};

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Entry count exceeds the stack depth.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("Sequencer returned to idle in the cycle after a transfer.");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (CW'(k_ff) < count_ff))
      else $error("Gap closing writes above the held entries.");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((state_ff == S_SHIFT) || (req_accept && (req_opcode == OP_PUSH))))
      else $error("Entry RAM written outside a push or a gap closing step.");

endmodule

// ===== src/lsia_ram.sv =====
// Entry store of the LIFO stack: one write port and one read port with
// registered read data. Does not depend on lsia_pkg.
module lsia_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W     = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
